>>> rtl/dhf_pkg.sv
`default_nettype none

package dhf_pkg;

   localparam int TABLE_SIZE   = 1048573;
   localparam int PROBE_STEP   = 137;
   localparam int STEP_MOD     = PROBE_STEP % TABLE_SIZE;

   localparam int POS_W        = 31;
   localparam int KEY_W        = 2 * POS_W;
   localparam int CNT_W        = 16;
   localparam int THR_W        = 16;
   localparam int EPOCH_W      = 8;
   localparam int SLOT_W       = $clog2(TABLE_SIZE);
   localparam int PROBE_W      = $clog2(TABLE_SIZE);
   localparam int ENTRY_W      = EPOCH_W + CNT_W + KEY_W;

   localparam int HASH_RADIX_W = 4;
   localparam int HASH_W       = ((KEY_W + HASH_RADIX_W - 1) / HASH_RADIX_W) * HASH_RADIX_W;
   localparam int HASH_STEPS   = HASH_W / HASH_RADIX_W;
   localparam int HASH_CNT_W   = $clog2(HASH_STEPS);

   localparam int REQ_DATA_W   = ((KEY_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((CNT_W + 7) / 8) * 8;
   localparam int RSP_USER_W   = 2;

   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIRED    = 1'd1;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [CNT_W-1:0]   count;
      logic [KEY_W-1:0]   key;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic epoch_inc;
      logic clear_step;
      logic hash_step;
      logic probe_check;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic epoch_max;
      logic clear_last;
      logic hash_last;
      logic probe_hit;
      logic probe_last;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/duplicate_read_hash_filter.sv
`default_nettype none

// channel   dir  handshake              payload
// req       in   req_tvalid/req_tready  tdata {pos_second, pos_first}, tuser start_new
// rsp       out  rsp_tvalid/rsp_tready  tdata occurrences, tuser {table_full, redundant}
// csr       in   csr_valid/csr_ready    csr_index, csr_data (0 threshold, 1 paired_mode)
//
// One item: accept, hash steps (4 key bits per cycle), probes (a table read and a check each), result.
// The registered table read sets the probe loop of a read state and a check state.
// After reset a sweep clears all 1048573 slots of the table; no item is taken meanwhile.
// start_new bumps an 8-bit epoch; every 256th one repeats the full sweep.
// A stalled result holds in the output register while the next item is taken.

module duplicate_read_hash_filter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [dhf_pkg::REQ_DATA_W-1:0]     req_tdata,   // pos_first, pos_second
   input  wire logic                               req_tuser,   // start_new
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [dhf_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // occurrences
   output logic      [dhf_pkg::RSP_USER_W-1:0]     rsp_tuser,   // redundant, table_full
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dhf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dhf_pkg::CSR_DATA_W-1:0]     csr_data
);

   import dhf_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic             rsp_redundant;
   logic             rsp_table_full;
   logic [CNT_W-1:0] rsp_occurrences;

   dhf_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_start_new (req_tuser),
      .req_tready    (req_tready),
      .cmd           (cmd),
      .status        (status)
   );

   dhf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_pos_first   (req_tdata[POS_W-1:0]),
      .req_pos_second  (req_tdata[KEY_W-1:POS_W]),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_redundant   (rsp_redundant),
      .rsp_table_full  (rsp_table_full),
      .rsp_occurrences (rsp_occurrences),
      .cmd             (cmd),
      .status          (status)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_occurrences);
   assign rsp_tuser = {rsp_table_full, rsp_redundant};

endmodule

`default_nettype wire

>>> rtl/dhf_ram.sv
`default_nettype none

module dhf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/dhf_ctrl.sv
`default_nettype none

module dhf_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_start_new,
   output logic                     req_tready,
   output dhf_pkg::cmd_type         cmd,
   input  wire dhf_pkg::status_type status
);

   import dhf_pkg::*;

   state_type st_ff, st_in;
   logic      resume_ff, resume_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_CLEAR;
         resume_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         resume_ff <= resume_in;
      end
   end

   always_comb begin
      st_in      = st_ff;
      resume_in  = resume_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (st_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               st_in     = resume_ff ? ST_HASH : ST_IDLE;
               resume_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               st_in      = ST_HASH;
               if (req_start_new) begin
                  cmd.epoch_inc = 1'b1;
                  // epoch wraps: old marks become ambiguous, sweep first
                  if (status.epoch_max) begin
                     st_in     = ST_CLEAR;
                     resume_in = 1'b1;
                  end
               end
            end
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            if (status.hash_last) begin
               st_in = ST_READ;
            end
         end
         ST_READ: begin
            st_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.probe_check = 1'b1;
            st_in = (status.probe_hit || status.probe_last) ? ST_EMIT : ST_READ;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               st_in    = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/dhf_dp.sv
`default_nettype none

module dhf_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [dhf_pkg::POS_W-1:0]          req_pos_first,
   input  wire logic [dhf_pkg::POS_W-1:0]          req_pos_second,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dhf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dhf_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_redundant,
   output logic                                    rsp_table_full,
   output logic      [dhf_pkg::CNT_W-1:0]          rsp_occurrences,
   input  wire dhf_pkg::cmd_type                   cmd,
   output dhf_pkg::status_type                     status
);

   import dhf_pkg::*;

   localparam logic [SLOT_W:0] MOD_EXT  = (SLOT_W + 1)'(TABLE_SIZE);
   localparam logic [SLOT_W:0] STEP_EXT = (SLOT_W + 1)'(STEP_MOD);

   logic [THR_W-1:0]      threshold_ff, threshold_in;
   logic                  paired_ff, paired_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [HASH_W-1:0]     hash_sh_ff, hash_sh_in;
   logic [HASH_CNT_W-1:0] hash_cnt_ff, hash_cnt_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [PROBE_W-1:0]    probes_ff, probes_in;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [CNT_W-1:0]      res_occ_ff, res_occ_in;
   logic                  res_red_ff, res_red_in;
   logic                  res_full_ff, res_full_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      rsp_occ_ff, rsp_occ_in;
   logic                  rsp_red_ff, rsp_red_in;
   logic                  rsp_full_ff, rsp_full_in;

   logic [POS_W-1:0]  pos_lo, pos_hi;
   logic [SLOT_W:0]   hash_acc;
   logic [SLOT_W-1:0] hash_rem;
   logic [SLOT_W:0]   slot_sum;
   logic [SLOT_W-1:0] slot_next;
   entry_type         rd_entry;
   entry_type         wr_entry;
   logic [ENTRY_W-1:0] rd_data;
   logic              wr_en;
   logic              slot_free;
   logic              slot_match;
   logic [CNT_W-1:0]  cnt_new;

   dhf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_entry),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   assign rd_entry   = entry_type'(rd_data);
   assign slot_free  = !((rd_entry.epoch == epoch_ff) && (rd_entry.count != '0));
   assign slot_match = (rd_entry.key == key_ff);
   assign cnt_new    = slot_free ? CNT_W'(1) :
                       (rd_entry.count == '1) ? rd_entry.count : rd_entry.count + 1'b1;

   assign pos_lo = (req_pos_first < req_pos_second) ? req_pos_first : req_pos_second;
   assign pos_hi = (req_pos_first < req_pos_second) ? req_pos_second : req_pos_first;

   // remainder mod table size, HASH_RADIX_W key bits per cycle, msb first
   always_comb begin
      hash_rem = slot_ff;
      hash_acc = '0;
      for (int i = 0; i < HASH_RADIX_W; i++) begin
         hash_acc = {hash_rem, hash_sh_ff[HASH_W-1-i]};
         if (hash_acc >= MOD_EXT) begin
            hash_acc = hash_acc - MOD_EXT;
         end
         hash_rem = hash_acc[SLOT_W-1:0];
      end
   end

   assign slot_sum  = {1'b0, slot_ff} + STEP_EXT;
   assign slot_next = (slot_sum >= MOD_EXT) ? SLOT_W'(slot_sum - MOD_EXT) : slot_sum[SLOT_W-1:0];

   always_comb begin
      wr_en    = 1'b0;
      wr_entry = '0;
      if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.probe_check && (slot_free || slot_match)) begin
         wr_en          = 1'b1;
         wr_entry.epoch = epoch_ff;
         wr_entry.count = cnt_new;
         wr_entry.key   = key_ff;
      end
   end

   always_comb begin
      threshold_in = threshold_ff;
      paired_in    = paired_ff;
      key_in       = key_ff;
      hash_sh_in   = hash_sh_ff;
      hash_cnt_in  = hash_cnt_ff;
      slot_in      = slot_ff;
      probes_in    = probes_ff;
      epoch_in     = epoch_ff;
      res_occ_in   = res_occ_ff;
      res_red_in   = res_red_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_full_in  = rsp_full_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_data[THR_W-1:0];
            CSR_PAIRED:    paired_in    = csr_data[0];
            default:       threshold_in = threshold_ff;
         endcase
      end

      if (cmd.accept) begin
         key_in      = paired_ff ? {pos_lo, pos_hi} : {{POS_W{1'b0}}, req_pos_first};
         hash_sh_in  = HASH_W'(paired_ff ? {pos_lo, pos_hi} : {{POS_W{1'b0}}, req_pos_first});
         hash_cnt_in = '0;
         slot_in     = '0;
         probes_in   = '0;
      end
      if (cmd.epoch_inc) begin
         epoch_in = epoch_ff + 1'b1;
      end
      if (cmd.clear_step) begin
         slot_in = (slot_ff == SLOT_W'(TABLE_SIZE - 1)) ? '0 : slot_ff + 1'b1;
      end
      if (cmd.hash_step) begin
         slot_in     = hash_rem;
         hash_sh_in  = hash_sh_ff << HASH_RADIX_W;
         hash_cnt_in = hash_cnt_ff + 1'b1;
      end
      if (cmd.probe_check) begin
         if (slot_free || slot_match) begin
            res_occ_in  = cnt_new;
            res_red_in  = (cnt_new > threshold_ff);
            res_full_in = 1'b0;
         end else if (status.probe_last) begin
            res_occ_in  = '0;
            res_red_in  = 1'b0;
            res_full_in = 1'b1;
         end else begin
            slot_in   = slot_next;
            probes_in = probes_ff + 1'b1;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_occ_in   = res_occ_ff;
         rsp_red_in   = res_red_ff;
         rsp_full_in  = res_full_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         paired_ff    <= 1'b0;
         slot_ff      <= '0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         paired_ff    <= paired_in;
         slot_ff      <= slot_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      hash_sh_ff  <= hash_sh_in;
      hash_cnt_ff <= hash_cnt_in;
      probes_ff   <= probes_in;
      res_occ_ff  <= res_occ_in;
      res_red_ff  <= res_red_in;
      res_full_ff <= res_full_in;
      rsp_occ_ff  <= rsp_occ_in;
      rsp_red_ff  <= rsp_red_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign status.epoch_max  = (epoch_ff == '1);
   assign status.clear_last = (slot_ff == SLOT_W'(TABLE_SIZE - 1));
   assign status.hash_last  = (hash_cnt_ff == HASH_CNT_W'(HASH_STEPS - 1));
   assign status.probe_hit  = slot_free || slot_match;
   assign status.probe_last = (probes_ff == PROBE_W'(TABLE_SIZE - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign csr_ready       = 1'b1;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_occurrences = rsp_occ_ff;
   assign rsp_redundant   = rsp_red_ff;
   assign rsp_table_full  = rsp_full_ff;

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff < SLOT_W'(TABLE_SIZE))
      else $error("slot index out of table");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken item");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> (rsp_occ_ff == '0 && !rsp_red_ff))
      else $error("table full result carries a count");

   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.probe_check && (slot_free || slot_match)) |=> (res_occ_ff != '0))
      else $error("stored key left with zero count");

endmodule

`default_nettype wire

>>> bench/dhf_checker.sv
module dhf_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [dhf_pkg::REQ_DATA_W-1:0]   req_tdata,   // pos_first, pos_second
   input  wire logic                             req_tuser,   // start_new
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [dhf_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // occurrences
   input  wire logic [dhf_pkg::RSP_USER_W-1:0]   rsp_tuser,   // redundant, table_full
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [dhf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [dhf_pkg::CSR_DATA_W-1:0]   csr_data,
   output int unsigned                           mismatches,
   output int unsigned                           awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   import dhf_pkg::*;

   typedef struct packed {
      logic             redundant;
      logic             table_full;
      logic [CNT_W-1:0] occurrences;
   } read_verdict_type;

   // sparse copy of the table: a missing slot is a free slot
   logic [KEY_W-1:0] slot_key   [int unsigned];
   logic [CNT_W-1:0] slot_count [int unsigned];
   logic [THR_W-1:0] threshold;
   logic             paired;
   read_verdict_type expected_verdicts[$];
   int unsigned      bad_count = 0;

   function automatic read_verdict_type tally_read(input logic start_new,
                                                   input logic [POS_W-1:0] pos_a,
                                                   input logic [POS_W-1:0] pos_b);
      logic [KEY_W-1:0] key;
      int unsigned      slot;
      int unsigned      probes;
      logic [CNT_W-1:0] count;
      bit               done;
      read_verdict_type v;
      if (start_new) begin
         slot_key.delete();
         slot_count.delete();
      end
      if (paired)
         key = (pos_a < pos_b) ? {pos_a, pos_b} : {pos_b, pos_a};
      else
         key = {{POS_W{1'b0}}, pos_a};
      slot  = int'(64'(key) % 64'(TABLE_SIZE));
      done  = 0;
      count = '0;
      for (probes = 0; probes < TABLE_SIZE && !done; probes++) begin
         if (!slot_count.exists(slot)) begin
            slot_key[slot]   = key;
            slot_count[slot] = CNT_W'(1);
            count = CNT_W'(1);
            done  = 1;
         end else if (slot_key[slot] == key) begin
            count = slot_count[slot];
            if (count != {CNT_W{1'b1}})
               count = count + 1'b1;
            slot_count[slot] = count;
            done = 1;
         end else begin
            slot = (slot + PROBE_STEP) % TABLE_SIZE;
         end
      end
      if (done) begin
         v.redundant   = (count > threshold);
         v.table_full  = 1'b0;
         v.occurrences = count;
      end else begin
         v.redundant   = 1'b0;
         v.table_full  = 1'b1;
         v.occurrences = '0;
      end
      return v;
   endfunction

   always @(posedge clock) begin : watch
      read_verdict_type seen;
      read_verdict_type want;
      if (reset) begin
         slot_key.delete();
         slot_count.delete();
         threshold = THRESHOLD_RESET;
         paired    = 1'b0;
         expected_verdicts.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: threshold = csr_data[THR_W-1:0];
               CSR_PAIRED:    paired    = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            seen.redundant   = rsp_tuser[0];
            seen.table_full  = rsp_tuser[1];
            seen.occurrences = rsp_tdata[CNT_W-1:0];
            if (expected_verdicts.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("%0t: unexpected result item red=%0d full=%0d occ=%0d",
                           $realtime, seen.redundant, seen.table_full, seen.occurrences);
            end else begin
               want = expected_verdicts.pop_front();
               if (seen !== want) begin
                  bad_count++;
                  if (bad_count <= 10)
                     $display({"%0t: mismatch expected red=%0d full=%0d occ=%0d,",
                               " got red=%0d full=%0d occ=%0d"}, $realtime,
                              want.redundant, want.table_full, want.occurrences,
                              seen.redundant, seen.table_full, seen.occurrences);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_verdicts.push_back(tally_read(req_tuser, req_tdata[POS_W-1:0],
                                                   req_tdata[KEY_W-1:POS_W]));
      end
      awaiting   <= expected_verdicts.size();
      mismatches <= bad_count;
   end

endmodule

>>> bench/duplicate_read_hash_filter_tb.sv
module duplicate_read_hash_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dhf_pkg::*;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;   // pos_first, pos_second
   logic                   req_tuser  = 1'b0; // start_new
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // occurrences
   logic [RSP_USER_W-1:0]  rsp_tuser;         // redundant, table_full
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;
   int unsigned            mismatches;
   int unsigned            awaiting;

   bit                     steady = 1'b0;
   logic [POS_W-1:0]       hot_first  [16];
   logic [POS_W-1:0]       hot_second [16];

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   duplicate_read_hash_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   dhf_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 38);
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic send_read(input logic start_new, input logic [POS_W-1:0] pos_a,
                            input logic [POS_W-1:0] pos_b);
      while (!steady && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-KEY_W){1'b0}}, pos_b, pos_a};
      req_tuser  <= start_new;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // keys that share a home slot or sit on one another's probe chain
   task automatic refill_hot_keys();
      int unsigned base;
      base = $urandom_range(0, TABLE_SIZE - 1);
      for (int i = 0; i < 16; i++) begin
         hot_first[i]  = POS_W'(base + (i % 4) * TABLE_SIZE + (i / 4) * PROBE_STEP);
         hot_second[i] = (i < 8) ? '0 : POS_W'($urandom_range(0, 1000));
      end
   endtask

   task automatic run_group(input int count);
      logic [POS_W-1:0] pos_a;
      logic [POS_W-1:0] pos_b;
      int               pick;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 70) begin
            pick = $urandom_range(15);
            if ($urandom_range(1)) begin
               pos_a = hot_first[pick];
               pos_b = hot_second[pick];
            end else begin
               pos_a = hot_second[pick];
               pos_b = hot_first[pick];
            end
            if (pos_a == '0 && hot_second[pick] == '0 && $urandom_range(1))
               pos_a = hot_first[pick];
         end else begin
            pos_a = POS_W'($urandom);
            pos_b = POS_W'($urandom);
         end
         send_read($urandom_range(39) == 0, pos_a, pos_b);
      end
      wait_idle();
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] thr;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_reg(CSR_THRESHOLD, 16'd1);
      write_reg(CSR_PAIRED, 16'd0);
      send_read(1'b1, '0, POS_MAX);
      send_read(1'b0, '0, '0);
      send_read(1'b0, POS_MAX, '0);
      send_read(1'b0, POS_W'(TABLE_SIZE), POS_W'(5));
      send_read(1'b0, POS_W'(2 * TABLE_SIZE), POS_MAX);
      send_read(1'b0, POS_W'(PROBE_STEP), '0);
      send_read(1'b0, POS_W'(TABLE_SIZE), POS_MAX);
      wait_idle();

      // mode switch inside a group: single key p equals paired key (0, p)
      write_reg(CSR_PAIRED, 16'd1);
      send_read(1'b0, '0, '0);
      send_read(1'b0, POS_MAX, '0);
      send_read(1'b0, POS_W'(9), POS_W'(5));
      send_read(1'b0, POS_W'(5), POS_W'(9));
      send_read(1'b0, POS_MAX, POS_MAX);
      send_read(1'b0, POS_MAX - 1'b1, POS_MAX);
      send_read(1'b1, POS_W'(1), POS_W'(2));
      send_read(1'b0, '0, '0);
      wait_idle();

      write_reg(CSR_THRESHOLD, 16'd0);
      send_read(1'b0, POS_W'(3), POS_W'(4));
      wait_idle();
      write_reg(CSR_THRESHOLD, 16'hFFFF);
      write_reg(CSR_PAIRED, 16'd0);
      send_read(1'b0, POS_W'(3), POS_MAX);
      send_read(1'b0, POS_W'(3), '0);
      wait_idle();
      write_reg(CSR_THRESHOLD, 16'hFFFE);
      send_read(1'b0, POS_W'(3), '0);
      wait_idle();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: thr = 16'd1;
            1: thr = 16'd2;
            2: thr = 16'd3;
            3: thr = CSR_DATA_W'($urandom_range(1, 8));
            4: thr = 16'd0;
            5: thr = 16'hFFFF;
            default: thr = CSR_DATA_W'($urandom);
         endcase
         write_reg(CSR_THRESHOLD, thr);
         write_reg(CSR_PAIRED, CSR_DATA_W'(phase % 2));
         refill_hot_keys();
         steady = (phase == 3);
         run_group(86);
      end
      steady = 1'b0;

      repeat (100) @(posedge clock);
      if (mismatches == 0 && awaiting == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
